>>> design/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared definitions for the 3x3 int8 convolution block
// Widths, register indexes and helpers used by the interfaces and the
// convolution datapath.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int unsigned MaxRowWidth = 1024;
  localparam int unsigned ColW        = $clog2(MaxRowWidth);
  localparam int unsigned RowCntW     = 16;
  localparam int unsigned KSize       = 3;
  localparam int unsigned KTaps       = KSize * KSize;
  localparam int unsigned FirstOut    = 2;
  localparam int unsigned PixW        = 8;
  localparam int unsigned SumW        = 32;
  localparam int unsigned ProdW       = 2 * PixW;
  localparam int unsigned DotW        = ProdW + $clog2(KTaps);
  localparam int unsigned WidthW      = 11;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = KSize * PixW;
  localparam int unsigned LineW       = 2 * PixW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowWidth  = 2'd0,
    CfgKernelTop = 2'd1,
    CfgKernelMid = 2'd2,
    CfgKernelBot = 2'd3
  } cfg_reg_e;

  typedef logic signed [PixW-1:0]  pix_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [ColW-1:0]         col_t;

  // Index of the last column for a programmed row width, clamped to the
  // supported range.
  function automatic col_t width_last(logic [WidthW-1:0] width);
    logic [WidthW-1:0] clamped;
    clamped = width;
    if (width < WidthW'(KSize)) begin
      clamped = WidthW'(KSize);
    end else if (width > WidthW'(MaxRowWidth)) begin
      clamped = WidthW'(MaxRowWidth);
    end
    return ColW'(clamped - WidthW'(1));
  endfunction

endpackage

>>> design/conv3_if.sv
// ----------------------------------------------------------------------------
// conv3 channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface conv3_pix_if;
  logic                valid;
  logic                ready;
  conv3_pkg::pix_t     pixel;
  conv3_pkg::sum_t     partial_sum;
  logic                frame_start;

  modport source (output valid, output pixel, output partial_sum, output frame_start,
                  input ready);
  modport sink   (input valid, input pixel, input partial_sum, input frame_start,
                  output ready);
endinterface

interface conv3_res_if;
  logic                valid;
  logic                ready;
  conv3_pkg::sum_t     sum;
  logic                row_end;

  modport source (output valid, output sum, output row_end, input ready);
  modport sink   (input valid, input sum, input row_end, output ready);
endinterface

interface conv3_cfg_if;
  logic                                  valid;
  logic                                  ready;
  conv3_pkg::cfg_reg_e                   index;
  logic [conv3_pkg::CfgDataW-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/conv3x3_int8_accumulate.sv
// ----------------------------------------------------------------------------
// conv3x3_int8_accumulate: streaming 3x3 stride-1 int8 convolution
// Slides a 3x3 window over a padded plane and adds a carried partial sum.
// ----------------------------------------------------------------------------
// Usage: pixels of a zero-padded plane enter in raster order on pix_i, each
// with the partial sum of the output it completes; frame_start marks the
// first pixel of a plane. Once the pixel's row and column are both at least
// two, one result leaves on res_o: the partial sum plus the 3x3 dot product,
// wrapping at 32 bits, with row_end set on the last output of a row.
// The row width and the three kernel rows are written on cfg_i while the
// block is idle; cfg_i is always ready.
// Throughput is one pixel per cycle while res_o is ready. The two rows
// above are held in a single 1024 x 16-bit memory, read when a pixel is
// taken and written back as the pixel moves on to the multipliers, so each
// entry sees one read and one write per pixel.
// The memory read for a request lands at the edge that accepts it; then
// multiply, adder tree and final add are each registered in turn. When
// res_o stalls, the internal stages fill up before pix_i drops ready.
// Reset clears the counters, the window, the kernel and sets the row width
// to three; the line memory is not cleared and is refilled by the first
// two rows of each plane.
// ----------------------------------------------------------------------------
module conv3x3_int8_accumulate (
  input  logic         clk_i,
  input  logic         rst_ni,
  conv3_cfg_if.sink    cfg_i,
  conv3_pix_if.sink    pix_i,
  conv3_res_if.source  res_o
);

  typedef struct packed {
    conv3_pkg::pix_t px;
    conv3_pkg::sum_t psum;
    conv3_pkg::col_t col;
    logic            emit;
    logic            last;
  } s1_t;

  // Configuration
  conv3_pkg::col_t                  wlast_q;
  logic [conv3_pkg::CfgDataW-1:0]   kern_q [conv3_pkg::KSize];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= conv3_pkg::width_last(conv3_pkg::WidthW'(conv3_pkg::KSize));
      for (int r = 0; r < conv3_pkg::KSize; r++) begin
        kern_q[r] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        conv3_pkg::CfgRowWidth:  wlast_q   <= conv3_pkg::width_last(
                                     cfg_i.data[conv3_pkg::WidthW-1:0]);
        conv3_pkg::CfgKernelTop: kern_q[0] <= cfg_i.data;
        conv3_pkg::CfgKernelMid: kern_q[1] <= cfg_i.data;
        conv3_pkg::CfgKernelBot: kern_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Stage enables, from the output backwards
  logic v1_q, v2_q, v3_q, ov_q;
  logic en1, en2, en3, en_o;
  logic accept;

  assign en_o   = !ov_q || res_o.ready;
  assign en3    = !v3_q || en_o;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign pix_i.ready = en1;
  assign accept = pix_i.valid && en1;

  // Column and row position of the incoming pixel
  conv3_pkg::col_t                 col_cnt_q, col_raw, col_cur;
  logic [conv3_pkg::RowCntW-1:0]   row_cnt_q, row_cur;
  logic                            last_cur, emit_cur;

  always_comb begin
    col_raw  = pix_i.frame_start ? '0 : col_cnt_q;
    row_cur  = pix_i.frame_start ? '0 : row_cnt_q;
    // After a width decrease a column past the end counts as the last one.
    col_cur  = (col_raw > wlast_q) ? wlast_q : col_raw;
    last_cur = (col_cur == wlast_q);
    emit_cur = (row_cur >= conv3_pkg::RowCntW'(conv3_pkg::FirstOut)) &&
               (col_cur >= conv3_pkg::ColW'(conv3_pkg::FirstOut));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (last_cur) begin
        col_cnt_q <= '0;
        row_cnt_q <= (row_cur == '1) ? row_cur : row_cur + 1'b1;
      end else begin
        col_cnt_q <= col_cur + 1'b1;
        row_cnt_q <= row_cur;
      end
    end
  end

  // Line memory: upper byte is two rows above, lower byte one row above.
  logic [conv3_pkg::LineW-1:0] line_mem [conv3_pkg::MaxRowWidth];
  logic [conv3_pkg::LineW-1:0] rd_q, fwd_data_q, line_rd, wr_data;
  logic                        fwd_q, wr_en;
  s1_t                         s1_q;
  conv3_pkg::pix_t             above2, above1;

  assign line_rd = fwd_q ? fwd_data_q : rd_q;
  assign above2  = line_rd[conv3_pkg::LineW-1:conv3_pkg::PixW];
  assign above1  = line_rd[conv3_pkg::PixW-1:0];
  assign wr_data = {above1, s1_q.px};
  assign wr_en   = v1_q && en2;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.col] <= wr_data;
    end
    if (accept) begin
      rd_q <= line_mem[col_cur];
    end
  end

  // A write-back to the entry being read in the same cycle is forwarded;
  // this only happens when a frame start repeats column zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= wr_en && (s1_q.col == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
      s1_q       <= '{px:   pix_i.pixel,
                      psum: pix_i.partial_sum,
                      col:  col_cur,
                      emit: emit_cur,
                      last: last_cur};
    end
  end

  // Window shift and products
  conv3_pkg::pix_t win_q [conv3_pkg::KSize][conv3_pkg::KSize];
  conv3_pkg::pix_t win_d [conv3_pkg::KSize][conv3_pkg::KSize];
  logic signed [conv3_pkg::ProdW-1:0] prod_d [conv3_pkg::KTaps];
  logic signed [conv3_pkg::ProdW-1:0] prod_q [conv3_pkg::KTaps];
  conv3_pkg::sum_t psum2_q, psum3_q;
  logic            last2_q, last3_q;

  always_comb begin
    for (int r = 0; r < conv3_pkg::KSize; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = above2;
    win_d[1][2] = above1;
    win_d[2][2] = s1_q.px;
    for (int r = 0; r < conv3_pkg::KSize; r++) begin
      for (int k = 0; k < conv3_pkg::KSize; k++) begin
        prod_d[r*conv3_pkg::KSize+k] =
          $signed(kern_q[r][k*conv3_pkg::PixW +: conv3_pkg::PixW]) * win_d[r][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < conv3_pkg::KSize; r++) begin
        for (int k = 0; k < conv3_pkg::KSize; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else if (wr_en) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q && s1_q.emit;
      if (en3) v3_q <= v2_q;
      if (en_o) ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q  <= prod_d;
      psum2_q <= s1_q.psum;
      last2_q <= s1_q.last;
    end
  end

  // Adder tree over the nine products
  logic signed [conv3_pkg::DotW-1:0] dot_d, dot_q;

  always_comb begin
    dot_d = '0;
    for (int i = 0; i < conv3_pkg::KTaps; i++) begin
      dot_d = dot_d + conv3_pkg::DotW'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dot_q   <= dot_d;
      psum3_q <= psum2_q;
      last3_q <= last2_q;
    end
  end

  // Output register
  conv3_pkg::sum_t sum_q;
  logic            row_end_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      sum_q     <= psum3_q + conv3_pkg::SumW'(dot_q);
      row_end_q <= last3_q;
    end
  end

  assign res_o.valid   = ov_q;
  assign res_o.sum     = sum_q;
  assign res_o.row_end = row_end_q;

endmodule

>>> bench/conv3x3_int8_accumulate_test.sv
// ----------------------------------------------------------------------------
// conv3x3_int8_accumulate_test: self-checking bench for the 3x3 int8 convolution
// Streams padded planes through the block under random back-pressure and
// compares every sum and row_end flag against an in-bench window model,
// across several row widths and kernels, including widths below the
// supported range.
// ----------------------------------------------------------------------------
module conv3x3_int8_accumulate_test;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PerSetting   = 140;

  typedef struct packed {
    conv3_pkg::pix_t pixel;
    conv3_pkg::sum_t partial_sum;
    logic            frame_start;
  } pixel_req_t;

  typedef struct packed {
    conv3_pkg::sum_t sum;
    logic            row_end;
  } conv_result_t;

  logic clk_i;
  logic rst_ni;

  conv3_cfg_if cfg_if ();
  conv3_pix_if pix_if ();
  conv3_res_if res_if ();

  conv3x3_int8_accumulate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  pixel_req_t   pixel_queue[$];
  conv_result_t pending_sums[$];
  pixel_req_t   next_req;
  conv_result_t oldest_sum;

  int unsigned pixels_queued;
  int unsigned pixels_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned stall_left;
  int unsigned hold_mark;
  bit          idling_on;

  // Shadow of the block's registers and datapath state.
  logic [conv3_pkg::WidthW-1:0]   width_q;
  logic [conv3_pkg::CfgDataW-1:0] kernel_q [conv3_pkg::KSize];
  logic [conv3_pkg::PixW-1:0]     line_top [conv3_pkg::MaxRowWidth];
  logic [conv3_pkg::PixW-1:0]     line_mid [conv3_pkg::MaxRowWidth];
  logic signed [7:0]              win [conv3_pkg::KSize][conv3_pkg::KSize];
  int unsigned                    col_cnt;
  int unsigned                    row_cnt;

  function automatic int unsigned clamp_width(int unsigned w);
    if (w < conv3_pkg::KSize) return conv3_pkg::KSize;
    if (w > conv3_pkg::MaxRowWidth) return conv3_pkg::MaxRowWidth;
    return w;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic conv3_pkg::pix_t rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return -8'sd128;
    if (r == 1) return 8'sd127;
    return conv3_pkg::pix_t'($urandom);
  endfunction

  function automatic conv3_pkg::sum_t rand_psum();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7fff_ffff;
    if (r == 1) return 32'sh8000_0000;
    return conv3_pkg::sum_t'($urandom);
  endfunction

  function automatic logic [conv3_pkg::CfgDataW-1:0] rand_kernel_row();
    logic [conv3_pkg::CfgDataW-1:0] row;
    int unsigned                    r;
    for (int k = 0; k < conv3_pkg::KSize; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2) row[8*k +: 8] = 8'h80;
      else if (r < 3) row[8*k +: 8] = 8'h7f;
      else row[8*k +: 8] = 8'($urandom);
    end
    return row;
  endfunction

  // Takes one pixel into the shadow line store and window and queues the
  // sum that the block should produce for it, if any.
  task automatic advance_window(conv3_pkg::pix_t px, conv3_pkg::sum_t psum, logic fs);
    int unsigned                w;
    int unsigned                col;
    logic [conv3_pkg::PixW-1:0] above2;
    logic [conv3_pkg::PixW-1:0] above1;
    logic                       last;
    logic signed [7:0]          wt;
    logic signed [31:0]         dot;
    conv_result_t               res;
    w = clamp_width(width_q);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = (col_cnt >= w) ? w - 1 : col_cnt;
    last = (col == w - 1);
    above2 = line_top[col];
    above1 = line_mid[col];
    line_top[col] = above1;
    line_mid[col] = px;
    for (int r = 0; r < conv3_pkg::KSize; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = px;
    if (row_cnt >= conv3_pkg::FirstOut && col >= conv3_pkg::FirstOut) begin
      dot = 0;
      for (int r = 0; r < conv3_pkg::KSize; r++) begin
        for (int k = 0; k < conv3_pkg::KSize; k++) begin
          wt = kernel_q[r][8*k +: 8];
          dot = dot + wt * win[r][k];
        end
      end
      res.sum = psum + dot;
      res.row_end = last;
      pending_sums.push_back(res);
    end
    if (last) begin
      col_cnt = 0;
      if (row_cnt < 16'hffff) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // Pixel driver: the next request goes out once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid       <= 1'b0;
      pix_if.pixel       <= '0;
      pix_if.partial_sum <= '0;
      pix_if.frame_start <= 1'b0;
      send_gap           <= 0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (send_gap != 0) begin
        send_gap     <= send_gap - 1;
        pix_if.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        next_req = pixel_queue.pop_front();
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= next_req.pixel;
        pix_if.partial_sum <= next_req.partial_sum;
        pix_if.frame_start <= next_req.frame_start;
        send_gap           <= idle_gap();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      advance_window(pix_if.pixel, pix_if.partial_sum, pix_if.frame_start);
      pixels_accepted <= pixels_accepted + 1;
    end
  end

  // Result ready: random stalls, plus two long holds that let the block fill
  // up and push back on the pixel stream.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_mark    <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ((results_checked == 60 || results_checked == 400) &&
                 hold_mark != results_checked) begin
      hold_mark    <= results_checked;
      stall_left   <= LongHold;
      res_if.ready <= 1'b0;
    end else begin
      ready_gap = idle_gap();
      res_if.ready <= (ready_gap == 0);
      stall_left   <= (ready_gap == 0) ? 0 : ready_gap - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_sums.size() == 0) begin
        $error("result with nothing pending: sum %0d row_end %0b", res_if.sum, res_if.row_end);
        mismatches++;
      end else begin
        oldest_sum = pending_sums.pop_front();
        if (res_if.sum !== oldest_sum.sum) begin
          $error("sum: expected %0d, got %0d", oldest_sum.sum, res_if.sum);
          mismatches++;
        end
        if (res_if.row_end !== oldest_sum.row_end) begin
          $error("row_end: expected %0b, got %0b", oldest_sum.row_end, res_if.row_end);
          mismatches++;
        end
      end
      results_checked <= results_checked + 1;
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_pixel(conv3_pkg::pix_t px, conv3_pkg::sum_t psum, logic fs);
    pixel_req_t req;
    while (pixel_queue.size() >= 256) @(negedge clk_i);
    req.pixel = px;
    req.partial_sum = psum;
    req.frame_start = fs;
    pixel_queue.push_back(req);
    pixels_queued++;
  endtask

  task automatic queue_plane(int unsigned cols, int unsigned rows, bit lead_start,
                             int unsigned stop_after, int unsigned noise_pct);
    for (int unsigned n = 0; n < cols * rows && n < stop_after; n++) begin
      push_pixel(rand_pixel(), rand_psum(),
                 (n == 0 && lead_start) || ($urandom_range(0, 99) < noise_pct));
    end
  endtask

  // Waits until every request is taken and every sum has come back, then
  // lets the pipeline run dry.
  task automatic settle();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || pixels_accepted != pixels_queued ||
           pending_sums.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(conv3_pkg::cfg_reg_e idx,
                                logic [conv3_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      conv3_pkg::CfgRowWidth:  width_q = value[conv3_pkg::WidthW-1:0];
      conv3_pkg::CfgKernelTop: kernel_q[0] = value;
      conv3_pkg::CfgKernelMid: kernel_q[1] = value;
      conv3_pkg::CfgKernelBot: kernel_q[2] = value;
      default: ;
    endcase
  endtask

  task automatic write_width(int unsigned w);
    write_register(conv3_pkg::CfgRowWidth, {13'($urandom), 11'(w)});
  endtask

  initial begin
    int unsigned w;
    int unsigned cols;
    int unsigned rows;
    int unsigned kind;
    int unsigned stop;
    int unsigned noise;
    int unsigned budget;
    bit          lead;

    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = conv3_pkg::CfgRowWidth;
    cfg_if.data = '0;
    idling_on = 1'b1;
    pixels_queued = 0;
    pixels_accepted = 0;
    results_checked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    width_q = 11'd3;
    for (int r = 0; r < conv3_pkg::KSize; r++) begin
      kernel_q[r] = '0;
      for (int k = 0; k < conv3_pkg::KSize; k++) win[r][k] = '0;
    end
    for (int i = 0; i < conv3_pkg::MaxRowWidth; i++) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
    col_cnt = 0;
    row_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all weights at -128 against extreme pixels so that the dot
    // product overflows the carried sum at its positive end.
    write_width(3);
    write_register(conv3_pkg::CfgKernelTop, {3{8'h80}});
    write_register(conv3_pkg::CfgKernelMid, {3{8'h80}});
    write_register(conv3_pkg::CfgKernelBot, {3{8'h80}});
    for (int n = 0; n < 13; n++) begin
      push_pixel((n < 9) ? -8'sd128 : ((n % 2) ? -8'sd128 : 8'sd127),
                 (n == 8) ? 32'sh7fff_ffff : (n == 11) ? 32'sh8000_0000 : rand_psum(),
                 n == 0);
    end
    // A new plane that starts in the middle of a row.
    for (int n = 0; n < 9; n++) begin
      push_pixel((n % 2) ? 8'sd127 : -8'sd128, (n == 8) ? 32'sh8000_0000 : rand_psum(),
                 n == 0);
    end

    for (int s = 0; s < 10; s++) begin
      settle();
      idling_on = 1'b1;
      if (s < 3) w = s + 1;
      else if (s == 9) w = $urandom_range(30, 40);
      else w = $urandom_range(3, 16);
      write_width(w);
      cols = clamp_width(w);
      write_register(conv3_pkg::CfgKernelTop,
                     (s == 1) ? {3{8'h7f}} : (s == 2) ? '0 : rand_kernel_row());
      write_register(conv3_pkg::CfgKernelMid, (s == 1) ? {3{8'h7f}} : rand_kernel_row());
      write_register(conv3_pkg::CfgKernelBot, (s == 1) ? {3{8'h7f}} : rand_kernel_row());
      budget = 0;
      lead = 1'b1;
      while (budget < PerSetting) begin
        idling_on = ($urandom_range(0, 3) != 0);
        rows = $urandom_range(3, 7);
        kind = $urandom_range(0, 9);
        stop = cols * rows;
        noise = 0;
        if (kind == 0) stop = $urandom_range(1, cols * rows);
        else if (kind == 1) noise = 4;
        queue_plane(cols, rows, lead || kind != 2, stop, noise);
        budget += stop;
        lead = 1'b0;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
